// File: sv/matrix_multiply_defines.svh
// ----------------------------------------------------------------------------
// matrix_multiply_defines.svh
// Assertion macros for the matrix multiplier. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matrix_multiply: same-cycle check failed");
// next-cycle implication
`define MM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matrix_multiply: next-cycle check failed");
`else
`define MM_ASSERT_IMP(label, ante, cons)
`define MM_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: sv/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Types and fixed constants shared by the matrix multiplier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

   localparam int CMD_WIDTH   = 2;
   localparam int IDX_WIDTH   = 3;   // row / column fields
   localparam int DIM_WIDTH   = 4;   // dimension registers
   localparam int VAL_WIDTH   = 16;  // element_value field
   localparam int SUM_WIDTH   = 35;  // product_sum field
   localparam int CSR_IDX_WIDTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_WRITE_LEFT  = 2'd0,
      CMD_WRITE_RIGHT = 2'd1,
      CMD_COMPUTE     = 2'd2,
      CMD_NOP         = 2'd3
   } mm_op_type;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLS = 2'd1;

   // tag carried along the MAC pipeline with each step
   typedef struct packed {
      logic [IDX_WIDTH-1:0] row;
      logic [IDX_WIDTH-1:0] col;
      logic                 first_k;
      logic                 last_k;
      logic                 last_elem;
   } mm_tag_type;

   // controller -> datapath
   typedef struct packed {
      logic                 wr_left;
      logic                 wr_right;
      logic [IDX_WIDTH-1:0] wr_row;
      logic [IDX_WIDTH-1:0] wr_col;
      logic                 issue;
      logic [IDX_WIDTH-1:0] k;
      mm_tag_type           tag;
   } mm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic advance;
      logic busy;
   } mm_status_type;

endpackage

`default_nettype wire

// File: sv/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Integer matrix multiplier: loads A and B element by element, emits A x B.
// ----------------------------------------------------------------------------
// Usage: write elements of A (cmd 0) and B (cmd 1) one transaction each. A
// compute transaction (cmd 2) then streams C = A x B in row-major order, one
// rsp transaction per element, rsp_last on the final one. A compute issues
// rows * cols * cols multiply-accumulates (up to 512 at 8 x 8), one per cycle
// while rsp is not back-pressured, and also occupies the block for pipeline
// fill and drain; the single multiplier and the one read port of each operand
// store set that rate. Back-pressure on rsp stalls the whole pipeline. No new
// request is taken until the last result has been taken.
// Dimension registers (csr index 0 rows, 1 cols) are sampled at the start of
// each compute; 0 acts as 1 and values above MAX_DIM act as MAX_DIM. Writes
// with an index at or above MAX_DIM are dropped. The stores are not cleared
// at reset: read only entries that were written. Sums wrap at 35 bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_multiply_defines.svh"

module matrix_multiply #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mm_pkg::CMD_WIDTH-1:0]        req_cmd,
   input  logic [mm_pkg::IDX_WIDTH-1:0]        req_row_index,
   input  logic [mm_pkg::IDX_WIDTH-1:0]        req_col_index,
   input  logic signed [mm_pkg::VAL_WIDTH-1:0] req_element_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mm_pkg::IDX_WIDTH-1:0]        rsp_out_row,
   output logic [mm_pkg::IDX_WIDTH-1:0]        rsp_out_col,
   output logic signed [mm_pkg::SUM_WIDTH-1:0] rsp_product_sum,
   output logic                                rsp_last,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mm_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [mm_pkg::DIM_WIDTH-1:0]        csr_data
);
   import mm_pkg::*;

   mm_cmd_type    cmd;
   mm_status_type status;

   // sequencer: csr registers, decode, i/j/k walk
   mm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .status        (status),
      .cmd           (cmd)
   );

   // stores, read -> multiply -> accumulate -> result register
   mm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .wr_value        (req_element_value),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_product_sum (rsp_product_sum),
      .rsp_last        (rsp_last)
   );

   // idle means every result of the previous compute has been taken
   `MM_ASSERT_IMP(a_idle_drained, req_ready, !rsp_valid)
   // a compute transaction locks out further requests
   `MM_ASSERT_NXT(a_compute_busy, req_valid && req_ready && (req_cmd == CMD_COMPUTE), !req_ready)
   // nothing follows the final result
   `MM_ASSERT_NXT(a_last_final, rsp_valid && rsp_ready && rsp_last, !rsp_valid)

endmodule

`default_nettype wire

// File: sv/mm_datapath.sv
// ----------------------------------------------------------------------------
// mm_datapath
// Operand stores, multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_datapath #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mm_pkg::mm_cmd_type                 cmd,
   input  logic [mm_pkg::VAL_WIDTH-1:0]       wr_value,
   output mm_pkg::mm_status_type              status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [mm_pkg::IDX_WIDTH-1:0]       rsp_out_row,
   output logic [mm_pkg::IDX_WIDTH-1:0]       rsp_out_col,
   output logic signed [mm_pkg::SUM_WIDTH-1:0] rsp_product_sum,
   output logic                               rsp_last
);
   import mm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PROD_W = 2 * ELEM_WIDTH;

   logic [ELEM_WIDTH-1:0] left_mem  [DEPTH];
   logic [ELEM_WIDTH-1:0] right_mem [DEPTH];

   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     a_addr;
   logic [ADDR_W-1:0]     b_addr;
   logic [ELEM_WIDTH-1:0] wr_elem;
   logic                  advance;

   logic [ELEM_WIDTH-1:0]    a_ff, b_ff;
   logic                     v1_ff, v2_ff;
   mm_tag_type               tag1_ff, tag2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_WIDTH-1:0] acc_ff, acc_in;

   logic                         out_valid_ff;
   logic [IDX_WIDTH-1:0]         out_row_ff, out_col_ff;
   logic signed [SUM_WIDTH-1:0]  out_sum_ff;
   logic                         out_last_ff;

   // whole pipeline holds while the result register is full and not taken
   assign advance = !out_valid_ff || rsp_ready;

   assign wr_addr = ADDR_W'(cmd.wr_row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.wr_col);
   assign a_addr  = ADDR_W'(cmd.tag.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.k);
   assign b_addr  = ADDR_W'(cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.tag.col);
   assign wr_elem = ELEM_WIDTH'($unsigned(wr_value));

   always_ff @(posedge clock) begin
      if (cmd.wr_left) begin
         left_mem[wr_addr] <= wr_elem;
      end
      if (advance) begin
         a_ff <= left_mem[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_right) begin
         right_mem[wr_addr] <= wr_elem;
      end
      if (advance) begin
         b_ff <= right_mem[b_addr];
      end
   end

   assign acc_in = (tag2_ff.first_k ? SUM_WIDTH'(0) : acc_ff) + SUM_WIDTH'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else if (advance) begin
         v1_ff        <= cmd.issue;
         tag1_ff      <= cmd.tag;
         v2_ff        <= v1_ff;
         tag2_ff      <= tag1_ff;
         prod_ff      <= $signed(a_ff) * $signed(b_ff);
         out_valid_ff <= v2_ff && tag2_ff.last_k;
         if (v2_ff) begin
            acc_ff <= acc_in;
         end
         if (v2_ff && tag2_ff.last_k) begin
            out_row_ff  <= tag2_ff.row;
            out_col_ff  <= tag2_ff.col;
            out_sum_ff  <= acc_in;
            out_last_ff <= tag2_ff.last_elem;
         end
      end
   end

   assign status.advance  = advance;
   assign status.busy     = v1_ff || v2_ff || out_valid_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_product_sum = out_sum_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

// File: sv/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl
// Dimension registers, command decode and the i/j/k sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mm_pkg::CMD_WIDTH-1:0]     req_cmd,
   input  logic [mm_pkg::IDX_WIDTH-1:0]     req_row_index,
   input  logic [mm_pkg::IDX_WIDTH-1:0]     req_col_index,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mm_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [mm_pkg::DIM_WIDTH-1:0]     csr_data,
   input  mm_pkg::mm_status_type            status,
   output mm_pkg::mm_cmd_type               cmd
);
   import mm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   localparam logic [DIM_WIDTH-1:0] DIM_MAX = DIM_WIDTH'(MAX_DIM);

   state_type            state_ff;
   logic [DIM_WIDTH-1:0] rows_ff, cols_ff;
   logic [DIM_WIDTH-1:0] nr_ff, nc_ff;
   logic [IDX_WIDTH-1:0] i_ff, j_ff, k_ff;
   logic [DIM_WIDTH-1:0] nr_in, nc_in;
   logic                 accept, in_range, k_end, j_end, i_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign in_range  = ({1'b0, req_row_index} < DIM_MAX) && ({1'b0, req_col_index} < DIM_MAX);

   // 0 acts as 1, anything above MAX_DIM as MAX_DIM
   assign nr_in = (rows_ff == '0) ? DIM_WIDTH'(1) : ((rows_ff > DIM_MAX) ? DIM_MAX : rows_ff);
   assign nc_in = (cols_ff == '0) ? DIM_WIDTH'(1) : ((cols_ff > DIM_MAX) ? DIM_MAX : cols_ff);

   assign k_end = ({1'b0, k_ff} == nc_ff - DIM_WIDTH'(1));
   assign j_end = ({1'b0, j_ff} == nc_ff - DIM_WIDTH'(1));
   assign i_end = ({1'b0, i_ff} == nr_ff - DIM_WIDTH'(1));

   always_comb begin
      cmd.wr_left       = accept && (req_cmd == CMD_WRITE_LEFT) && in_range;
      cmd.wr_right      = accept && (req_cmd == CMD_WRITE_RIGHT) && in_range;
      cmd.wr_row        = req_row_index;
      cmd.wr_col        = req_col_index;
      cmd.issue         = (state_ff == ST_RUN);
      cmd.k             = k_ff;
      cmd.tag.row       = i_ff;
      cmd.tag.col       = j_ff;
      cmd.tag.first_k   = (k_ff == '0);
      cmd.tag.last_k    = k_end;
      cmd.tag.last_elem = k_end && j_end && i_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_WIDTH'(8);
         cols_ff  <= DIM_WIDTH'(8);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ROWS) begin
            rows_ff <= csr_data;
         end else if (csr_index == CSR_COLS) begin
            cols_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         nr_ff    <= DIM_WIDTH'(1);
         nc_ff    <= DIM_WIDTH'(1);
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_cmd == CMD_COMPUTE)) begin
                  state_ff <= ST_RUN;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  nr_ff    <= nr_in;
                  nc_ff    <= nc_in;
               end
            end
            ST_RUN: begin
               if (status.advance) begin
                  if (k_end) begin
                     k_ff <= '0;
                     if (j_end) begin
                        j_ff <= '0;
                        i_ff <= i_ff + IDX_WIDTH'(1);
                        if (i_end) begin
                           state_ff <= ST_DRAIN;
                        end
                     end else begin
                        j_ff <= j_ff + IDX_WIDTH'(1);
                     end
                  end else begin
                     k_ff <= k_ff + IDX_WIDTH'(1);
                  end
               end
            end
            ST_DRAIN: begin
               if (!status.busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
